@@ rtl/window_max_filter_2d_top_assert.svh @@
// Assertion macros for the window max filter.
`ifndef WINDOW_MAX_FILTER_2D_TOP_ASSERT_SVH
`define WINDOW_MAX_FILTER_2D_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define WMF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define WMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wmf_pkg.sv @@
`default_nettype none

package wmf_pkg;

    localparam int MAX_FRAME_WIDTH_DFLT = 1024;
    localparam int MAX_WINDOW_DFLT      = 64;
    localparam int PIXEL_BITS_DFLT      = 16;
    localparam int FRAME_HEIGHT_CAP     = 1024;

    localparam int PIXEL_FIELD_BITS = 16;
    localparam int POS_FIELD_BITS   = 10;
    localparam int WIN_REG_BITS     = 7;
    localparam int FRAME_REG_BITS   = 11;
    localparam int APB_ADDR_BITS    = 4;
    localparam int APB_DATA_BITS    = 32;
    localparam int M_TDATA_BITS     = 40;

    localparam logic [1:0] REG_WINDOW_HEIGHT = 2'd0;
    localparam logic [1:0] REG_WINDOW_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd3;

    // per-cycle controls shared by every cell of the chain
    typedef struct packed {
        logic step;   // item accepted: shift row taps, read line column
        logic write;  // write back the column's updated vertical maxima
    } wmf_cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/window_max_filter_2d_top.sv @@
// 2-D sliding window maximum over a raster pixel stream.
// s_ channel: one pixel per item, raster order, frame size from registers.
// m_ channel: one item per window fully inside the frame, sent when the
// window's bottom-right pixel is taken; m_tlast marks the frame's last window.
// APB registers: window height/width and frame height/width at 0x0..0xC.
// Any register write restarts the frame at row 0, column 0.
// A result passes the stage 1 registers, then the output register.
// Throughput: one pixel per cycle unless stalled; the chain of MAX_WINDOW-1
// cells does one horizontal and one vertical max step per cell per pixel,
// each cell owning a one-read one-write line store of MAX_FRAME_WIDTH entries.
// Reset clears counters, the pipeline and output valid, and sets the window
// to 1x1 and the frame to 1024x1024. Line stores are not cleared.
// When m_tready is low the result holds. Pixels that complete no window keep
// flowing; the next pixel that completes one waits in the stage behind the
// result, and s_tready stays low until the result is taken.
`default_nettype none

module window_max_filter_2d_top #(
    parameter int MAX_FRAME_WIDTH = wmf_pkg::MAX_FRAME_WIDTH_DFLT,
    parameter int MAX_WINDOW      = wmf_pkg::MAX_WINDOW_DFLT,
    parameter int PIXEL_BITS      = wmf_pkg::PIXEL_BITS_DFLT
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [wmf_pkg::PIXEL_FIELD_BITS-1:0] s_tdata,  // [15:0] pixel
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [15:0] window_max, [25:16] top_row, [35:26] left_col, [39:36] zero
    output logic [wmf_pkg::M_TDATA_BITS-1:0]    m_tdata,
    output logic                                m_tlast,   // last_window
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [wmf_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire  [wmf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [wmf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    localparam int CELLS = MAX_WINDOW - 1;
    localparam int CIDX  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int AW    = $clog2(MAX_FRAME_WIDTH);
    localparam int FB    = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int WB    = $clog2(MAX_WINDOW + 1);
    localparam int RB    = wmf_pkg::POS_FIELD_BITS;
    localparam int HB    = wmf_pkg::FRAME_REG_BITS;
    localparam int CW    = ((AW > WB) ? AW : WB) + 1;
    localparam int LW    = (CW > RB) ? CW : RB;
    localparam int VW    = ((HB > WB) ? HB : WB) + 1;
    localparam int XW    = (PIXEL_BITS > wmf_pkg::PIXEL_FIELD_BITS) ?
                           PIXEL_BITS : wmf_pkg::PIXEL_FIELD_BITS;

    // ---------------- configuration ----------------
    logic [wmf_pkg::WIN_REG_BITS-1:0]   win_h_reg;
    logic [wmf_pkg::WIN_REG_BITS-1:0]   win_w_reg;
    logic [wmf_pkg::FRAME_REG_BITS-1:0] frm_h_reg;
    logic [wmf_pkg::FRAME_REG_BITS-1:0] frm_w_reg;
    logic                               cfg_wr;
    logic [1:0]                         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_h_reg <= wmf_pkg::WIN_REG_BITS'(1);
            win_w_reg <= wmf_pkg::WIN_REG_BITS'(1);
            frm_h_reg <= wmf_pkg::FRAME_REG_BITS'(1024);
            frm_w_reg <= wmf_pkg::FRAME_REG_BITS'(1024);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                wmf_pkg::REG_WINDOW_HEIGHT: win_h_reg <= pwdata[wmf_pkg::WIN_REG_BITS-1:0];
                wmf_pkg::REG_WINDOW_WIDTH:  win_w_reg <= pwdata[wmf_pkg::WIN_REG_BITS-1:0];
                wmf_pkg::REG_FRAME_HEIGHT:  frm_h_reg <= pwdata[wmf_pkg::FRAME_REG_BITS-1:0];
                wmf_pkg::REG_FRAME_WIDTH:   frm_w_reg <= pwdata[wmf_pkg::FRAME_REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            wmf_pkg::REG_WINDOW_HEIGHT: prdata = wmf_pkg::APB_DATA_BITS'(win_h_reg);
            wmf_pkg::REG_WINDOW_WIDTH:  prdata = wmf_pkg::APB_DATA_BITS'(win_w_reg);
            wmf_pkg::REG_FRAME_HEIGHT:  prdata = wmf_pkg::APB_DATA_BITS'(frm_h_reg);
            wmf_pkg::REG_FRAME_WIDTH:   prdata = wmf_pkg::APB_DATA_BITS'(frm_w_reg);
            default:                    prdata = '0;
        endcase
    end

    // clamped sizes: zero counts as one, oversize counts as the maximum
    logic [WB-1:0] wh_eff;
    logic [WB-1:0] ww_eff;
    logic [HB-1:0] fh_eff;
    logic [FB-1:0] fw_eff;

    always_comb begin
        if (win_h_reg == '0)             wh_eff = WB'(1);
        else if (win_h_reg > MAX_WINDOW) wh_eff = WB'(MAX_WINDOW);
        else                             wh_eff = WB'(win_h_reg);

        if (win_w_reg == '0)             ww_eff = WB'(1);
        else if (win_w_reg > MAX_WINDOW) ww_eff = WB'(MAX_WINDOW);
        else                             ww_eff = WB'(win_w_reg);

        if (frm_h_reg == '0)                            fh_eff = HB'(1);
        else if (frm_h_reg > wmf_pkg::FRAME_HEIGHT_CAP) fh_eff = HB'(wmf_pkg::FRAME_HEIGHT_CAP);
        else                                            fh_eff = frm_h_reg;

        if (frm_w_reg == '0)                  fw_eff = FB'(1);
        else if (frm_w_reg > MAX_FRAME_WIDTH) fw_eff = FB'(MAX_FRAME_WIDTH);
        else                                  fw_eff = FB'(frm_w_reg);
    end

    // ---------------- stage 0: accept, position, row max ----------------
    logic [AW-1:0]         col_count_reg;
    logic [RB-1:0]         row_count_reg;
    logic                  accept;
    logic                  s1_adv;
    logic                  s1_valid_reg;
    logic [XW-1:0]         px_wide;
    logic [PIXEL_BITS-1:0] px;
    logic [PIXEL_BITS-1:0] h_tap  [CELLS];
    logic [PIXEL_BITS-1:0] d_tap  [CELLS];
    logic [CIDX-1:0]       hsel;
    logic [CIDX-1:0]       vsel;
    logic [PIXEL_BITS-1:0] row_max;
    logic                  col_wrap;
    logic                  row_wrap;
    logic                  h_full;
    logic                  v_full;
    logic [LW-1:0]         left_full;
    logic [VW-1:0]         top_full;
    logic                  frame_end;

    assign s_tready = aresetn && (!s1_valid_reg || s1_adv);
    assign accept   = s_tvalid && s_tready;

    assign px_wide = XW'(s_tdata);
    assign px      = px_wide[PIXEL_BITS-1:0];

    assign hsel    = CIDX'(ww_eff - WB'(2));
    assign vsel    = CIDX'(wh_eff - WB'(2));
    assign row_max = (ww_eff == WB'(1)) ? px :
                     ((h_tap[hsel] > px) ? h_tap[hsel] : px);

    assign col_wrap  = (FB'(col_count_reg) + FB'(1)) >= fw_eff;
    assign row_wrap  = (HB'(row_count_reg) + HB'(1)) >= fh_eff;
    assign h_full    = (CW'(col_count_reg) + CW'(1)) >= CW'(ww_eff);
    assign v_full    = (VW'(row_count_reg) + VW'(1)) >= VW'(wh_eff);
    assign left_full = LW'(col_count_reg) + LW'(1) - LW'(ww_eff);
    assign top_full  = VW'(row_count_reg) + VW'(1) - VW'(wh_eff);
    assign frame_end = col_wrap && row_wrap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (cfg_wr) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                col_count_reg <= '0;
                row_count_reg <= row_wrap ? '0 : row_count_reg + RB'(1);
            end else begin
                col_count_reg <= col_count_reg + AW'(1);
            end
        end
    end

    // ---------------- stage 1: column read back, vertical max ----------------
    logic                  s1_emit_reg;
    logic                  s1_write_reg;
    logic [PIXEL_BITS-1:0] s1_rm_reg;
    logic [AW-1:0]         s1_col_reg;
    logic [RB-1:0]         s1_top_reg;
    logic [RB-1:0]         s1_left_reg;
    logic                  s1_last_reg;
    logic                  m_valid_reg;

    assign s1_adv = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_write_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
            s1_emit_reg  <= h_full && v_full;
            s1_write_reg <= h_full;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_rm_reg   <= row_max;
            s1_col_reg  <= col_count_reg;
            s1_top_reg  <= top_full[RB-1:0];
            s1_left_reg <= left_full[RB-1:0];
            s1_last_reg <= frame_end;
        end
    end

    wmf_pkg::wmf_cell_ctrl_t cell_ctrl;

    assign cell_ctrl.step  = accept;
    assign cell_ctrl.write = s1_adv && s1_write_reg;

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        logic [PIXEL_BITS-1:0] h_prev;
        logic [PIXEL_BITS-1:0] d_prev;

        if (k == 0) begin : g_head
            assign h_prev = '0;
            assign d_prev = '0;
        end else begin : g_link
            assign h_prev = h_tap[k-1];
            assign d_prev = d_tap[k-1];
        end

        wmf_cell #(
            .PB    (PIXEL_BITS),
            .DEPTH (MAX_FRAME_WIDTH),
            .AW    (AW)
        ) u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctrl),
            .px      (px),
            .h_prev  (h_prev),
            .h_out   (h_tap[k]),
            .rd_addr (col_count_reg),
            .wr_addr (s1_col_reg),
            .row_max (s1_rm_reg),
            .d_prev  (d_prev),
            .d_out   (d_tap[k])
        );
    end

    logic [PIXEL_BITS-1:0] win_max;
    logic [XW-1:0]         win_max_wide;

    assign win_max = (wh_eff == WB'(1)) ? s1_rm_reg :
                     ((d_tap[vsel] > s1_rm_reg) ? d_tap[vsel] : s1_rm_reg);
    assign win_max_wide = XW'(win_max);

    // ---------------- output register ----------------
    logic [wmf_pkg::PIXEL_FIELD_BITS-1:0] m_max_reg;
    logic [RB-1:0]                        m_top_reg;
    logic [RB-1:0]                        m_left_reg;
    logic                                 m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            m_max_reg  <= win_max_wide[wmf_pkg::PIXEL_FIELD_BITS-1:0];
            m_top_reg  <= s1_top_reg;
            m_left_reg <= s1_left_reg;
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_left_reg, m_top_reg, m_max_reg};
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
`include "window_max_filter_2d_top_assert.svh"

    `WMF_ASSERT_NOW(a_col_in_frame, 1'b1, FB'(col_count_reg) < fw_eff, "column count past frame width")
    `WMF_ASSERT_NOW(a_no_take_when_held, s1_valid_reg && !s1_adv, !s_tready, "item taken while stage 1 held")
    `WMF_ASSERT_NEXT(a_held_item_stays, s1_valid_reg && !s1_adv, s1_valid_reg && $stable(s1_col_reg), "held stage 1 item lost")

endmodule

`default_nettype wire

@@ rtl/wmf_cell.sv @@
`default_nettype none

// One cell of the max chain. Horizontally it keeps the max of the last k+1
// pixels of the row; vertically it keeps, per column, the max of the last
// k+1 row maxima. Cell k builds both from cell k-1's values.
module wmf_cell #(
    parameter int PB    = wmf_pkg::PIXEL_BITS_DFLT,
    parameter int DEPTH = wmf_pkg::MAX_FRAME_WIDTH_DFLT,
    parameter int AW    = $clog2(wmf_pkg::MAX_FRAME_WIDTH_DFLT)
) (
    input  wire                        aclk,
    input  wmf_pkg::wmf_cell_ctrl_t    ctrl,
    input  wire  [PB-1:0]              px,
    input  wire  [PB-1:0]              h_prev,
    output logic [PB-1:0]              h_out,
    input  wire  [AW-1:0]              rd_addr,
    input  wire  [AW-1:0]              wr_addr,
    input  wire  [PB-1:0]              row_max,
    input  wire  [PB-1:0]              d_prev,
    output logic [PB-1:0]              d_out
);

    logic [PB-1:0] line_mem [DEPTH];
    logic [PB-1:0] h_reg;
    logic [PB-1:0] h_next;
    logic [PB-1:0] d_reg;
    logic [PB-1:0] wr_val;

    assign h_next = (h_prev > px) ? h_prev : px;
    assign wr_val = (d_prev > row_max) ? d_prev : row_max;

    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            h_reg <= h_next;
        end
    end

    // a one-column frame reads the column being written in the same cycle
    always_ff @(posedge aclk) begin
        if (ctrl.write) begin
            line_mem[wr_addr] <= wr_val;
        end
        if (ctrl.step) begin
            d_reg <= (ctrl.write && (wr_addr == rd_addr)) ? wr_val : line_mem[rd_addr];
        end
    end

    assign h_out = h_reg;
    assign d_out = d_reg;

endmodule

`default_nettype wire
